FILE: rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB colour converter.
// ----------------------------------------------------------------------------

package hsv2rgb_pkg;

  // Ramp step per hue count and hue counts per wheel segment
  localparam int unsigned HsvStep   = 771;
  localparam int unsigned HsvSeg    = 85;
  // First hue of the second and third segments
  localparam int unsigned HsvSeg2Lo = 86;
  localparam int unsigned HsvSeg3Lo = 171;
  localparam int unsigned HsvSeg3Of = 170;
  // Ramp ceiling and blend levels
  localparam int unsigned HsvClamp  = 32768;
  localparam int unsigned HsvHalf   = 128;
  localparam int unsigned HsvFull   = 256;

  localparam int unsigned RampW  = 16;  // clamped ramp, at most 32768
  localparam int unsigned BlendW = 15;  // after saturation blend, below 32768
  localparam int unsigned OffW   = 15;  // white offset, at most 127 * 256
  localparam int unsigned SegHW  = 7;   // position within a segment, 0..85

  // Input and result beats
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_pix_t;

  // Hue wheel segment
  typedef enum logic [2:0] {
    SEG_RG = 3'b001,
    SEG_GB = 3'b010,
    SEG_BR = 3'b100
  } seg_e;

  // Stage load enables of the channel blend pipeline
  typedef struct packed {
    logic s3;
    logic s4;
  } stg_en_t;

endpackage

FILE: rtl/hsv2rgb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_in_if / hsv2rgb_out_if
// Valid/ready channels carrying HSV input beats and RGB result beats.
// ----------------------------------------------------------------------------

interface hsv2rgb_in_if;
  logic                  valid;
  logic                  ready;
  hsv2rgb_pkg::hsv_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                  valid;
  logic                  ready;
  hsv2rgb_pkg::rgb_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hsv_to_rgb_colour_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_colour_converter
// Four-stage pipeline from 8-bit hue, saturation, brightness to 8-bit RGB.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled; the fourth
// stage is the output register. Stage one picks the hue segment and the
// ramp positions, stage two multiplies by the ramp step and clamps, stage
// three blends with saturation and stage four applies brightness, these
// last two each behind one 16x8 or smaller multiplier per channel. Each
// stage holds while the one after it is full and stalled, and empty stages
// close up, so a stall on the output loses or repeats nothing and the
// input stays ready while any stage is free.

module hsv_to_rgb_colour_converter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsv2rgb_in_if.sink           in_i,
  hsv2rgb_out_if.source        out_o
);

  // Stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  hsv2rgb_pkg::stg_en_t ch_en;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;
  assign ch_en.s3 = en3;
  assign ch_en.s4 = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: segment decode
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::seg_e                  seg_d, seg_q;
  logic [hsv2rgb_pkg::SegHW-1:0]      fall_d, fall_q;  // 85 - h
  logic [hsv2rgb_pkg::SegHW-1:0]      rise_d, rise_q;  // h
  logic [7:0]                         sat1_q, val1_q;
  logic [7:0]                         hpos;

  always_comb begin
    if (in_i.data.hue < 8'(hsv2rgb_pkg::HsvSeg2Lo)) begin
      seg_d = hsv2rgb_pkg::SEG_RG;
      hpos  = in_i.data.hue;
    end else if (in_i.data.hue < 8'(hsv2rgb_pkg::HsvSeg3Lo)) begin
      seg_d = hsv2rgb_pkg::SEG_GB;
      hpos  = in_i.data.hue - 8'(hsv2rgb_pkg::HsvSeg);
    end else begin
      seg_d = hsv2rgb_pkg::SEG_BR;
      hpos  = in_i.data.hue - 8'(hsv2rgb_pkg::HsvSeg3Of);
    end
    rise_d = hpos[hsv2rgb_pkg::SegHW-1:0];
    fall_d = hsv2rgb_pkg::SegHW'(hsv2rgb_pkg::HsvSeg) - rise_d;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      seg_q  <= seg_d;
      fall_q <= fall_d;
      rise_q <= rise_d;
      sat1_q <= in_i.data.saturation;
      val1_q <= in_i.data.brightness;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ramp multiply and clamp, brightness factor
  // --------------------------------------------------------------------------
  logic [16:0]                        fall_prod, rise_prod;
  logic [hsv2rgb_pkg::RampW-1:0]      fall_cl, rise_cl;
  logic [hsv2rgb_pkg::RampW-1:0]      r_d, g_d, b_d, r_q, g_q, b_q;
  logic [7:0]                         mul_d, mul2_q, sat2_q;
  logic [hsv2rgb_pkg::OffW-1:0]       off_d, off2_q;
  logic [8:0]                         val_inv;

  always_comb begin
    fall_prod = 17'(fall_q) * 17'(hsv2rgb_pkg::HsvStep);
    rise_prod = 17'(rise_q) * 17'(hsv2rgb_pkg::HsvStep);
    fall_cl = (fall_prod > 17'(hsv2rgb_pkg::HsvClamp)) ?
              hsv2rgb_pkg::RampW'(hsv2rgb_pkg::HsvClamp) : fall_prod[15:0];
    rise_cl = (rise_prod > 17'(hsv2rgb_pkg::HsvClamp)) ?
              hsv2rgb_pkg::RampW'(hsv2rgb_pkg::HsvClamp) : rise_prod[15:0];
    case (seg_q)
      hsv2rgb_pkg::SEG_RG: begin
        r_d = fall_cl;
        g_d = rise_cl;
        b_d = '0;
      end
      hsv2rgb_pkg::SEG_GB: begin
        r_d = '0;
        g_d = fall_cl;
        b_d = rise_cl;
      end
      hsv2rgb_pkg::SEG_BR: begin
        r_d = rise_cl;
        g_d = '0;
        b_d = fall_cl;
      end
      default: begin
        r_d = '0;
        g_d = '0;
        b_d = '0;
      end
    endcase

    // Above half: scale by (256 - val) and add (val - 128) * 256
    val_inv = 9'(hsv2rgb_pkg::HsvFull) - {1'b0, val1_q};
    if (val1_q > 8'(hsv2rgb_pkg::HsvHalf)) begin
      mul_d = val_inv[7:0];
      off_d = {val1_q[6:0], 8'b0};
    end else begin
      mul_d = val1_q;
      off_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      r_q    <= r_d;
      g_q    <= g_d;
      b_q    <= b_d;
      sat2_q <= sat1_q;
      mul2_q <= mul_d;
      off2_q <= off_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: carry brightness factor alongside the saturation blend
  // --------------------------------------------------------------------------
  logic [7:0]                    mul3_q;
  logic [hsv2rgb_pkg::OffW-1:0]  off3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mul3_q <= mul2_q;
      off3_q <= off2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: per-channel blend
  // --------------------------------------------------------------------------
  hsv2rgb_chan u_chan_r (
    .clk_i  (clk_i),
    .en_i   (ch_en),
    .ramp_i (r_q),
    .sat_i  (sat2_q),
    .mul_i  (mul3_q),
    .off_i  (off3_q),
    .res_o  (out_o.data.red_out)
  );

  hsv2rgb_chan u_chan_g (
    .clk_i  (clk_i),
    .en_i   (ch_en),
    .ramp_i (g_q),
    .sat_i  (sat2_q),
    .mul_i  (mul3_q),
    .off_i  (off3_q),
    .res_o  (out_o.data.green_out)
  );

  hsv2rgb_chan u_chan_b (
    .clk_i  (clk_i),
    .en_i   (ch_en),
    .ramp_i (b_q),
    .sat_i  (sat2_q),
    .mul_i  (mul3_q),
    .off_i  (off3_q),
    .res_o  (out_o.data.blue_out)
  );

  assign out_o.valid = v4_q;

endmodule

FILE: rtl/hsv2rgb_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// Saturation and brightness blend of one colour channel, two register stages.
// ----------------------------------------------------------------------------

module hsv2rgb_chan (
  input  logic                                 clk_i,
  input  hsv2rgb_pkg::stg_en_t                 en_i,
  input  logic [hsv2rgb_pkg::RampW-1:0]        ramp_i,
  input  logic [7:0]                           sat_i,
  input  logic [7:0]                           mul_i,
  input  logic [hsv2rgb_pkg::OffW-1:0]         off_i,
  output logic [7:0]                           res_o
);

  logic [hsv2rgb_pkg::BlendW-1:0] blend_d, blend_q;
  logic [23:0]                    sat_prod;
  logic [8:0]                     sat_inv;
  logic [16:0]                    blend_sum;
  logic [22:0]                    val_prod;
  logic [16:0]                    val_sum;
  logic [7:0]                     res_d, res_q;

  // Blend toward mid grey by saturation
  always_comb begin
    sat_prod  = 24'(ramp_i) * 24'(sat_i);
    sat_inv   = 9'(hsv2rgb_pkg::HsvFull) - {1'b0, sat_i};
    blend_sum = 17'(sat_prod[23:8]) + 17'({sat_inv, 6'b0});
    blend_d   = blend_sum[hsv2rgb_pkg::BlendW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      blend_q <= blend_d;
    end
  end

  // Scale toward black, or toward white with the offset, then drop 7 bits
  always_comb begin
    val_prod = 23'(blend_q) * 23'(mul_i);
    val_sum  = 17'(val_prod[22:7]) + 17'(off_i);
    res_d    = val_sum[14:7];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: dv/hsv_to_rgb_colour_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_colour_converter_checker
// Passive monitor and scoreboard of the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
// Watches both valid/ready channels. Every accepted HSV beat is turned into
// its expected RGB colour by a bit-exact software version of the conversion
// and queued. Every accepted RGB beat is compared field by field with the
// oldest queued colour. The mismatch count and the number of colours still
// outstanding are handed to the testbench top.

module hsv_to_rgb_colour_converter_checker (
  input  logic    clk_i,
  input  logic    rst_ni,
  hsv2rgb_in_if   pix_in_mon,
  hsv2rgb_out_if  pix_out_mon,
  output int      err_cnt_o,
  output int      pend_cnt_o
);

  // Mid grey weight per unit of missing saturation
  localparam int unsigned MidUnit  = 64;

  hsv2rgb_pkg::rgb_pix_t rgb_exp_q[$];

  // Blend one clamped ramp level with saturation, then with brightness
  function automatic logic [7:0] blend_channel(input int unsigned ramp,
                                               input logic [7:0]  sat,
                                               input logic [7:0]  bri);
    int unsigned lvl;
    int unsigned white;
    lvl = ramp * sat / hsv2rgb_pkg::HsvFull + (hsv2rgb_pkg::HsvFull - sat) * MidUnit;
    if (bri > hsv2rgb_pkg::HsvHalf) begin
      white = bri - hsv2rgb_pkg::HsvHalf;
      lvl   = lvl * (hsv2rgb_pkg::HsvHalf - white) / hsv2rgb_pkg::HsvHalf +
              white * hsv2rgb_pkg::HsvFull;
    end else begin
      lvl = lvl * bri / hsv2rgb_pkg::HsvHalf;
    end
    lvl = lvl >> 7;
    return lvl[7:0];
  endfunction

  // Predict the colour of one HSV pixel
  function automatic hsv2rgb_pkg::rgb_pix_t hsv_to_rgb(input hsv2rgb_pkg::hsv_pix_t pix);
    hsv2rgb_pkg::seg_e     seg;
    int unsigned           pos;
    int unsigned           rise;
    int unsigned           fall;
    int unsigned           ramp_r;
    int unsigned           ramp_g;
    int unsigned           ramp_b;
    hsv2rgb_pkg::rgb_pix_t rgb;
    if (pix.hue < hsv2rgb_pkg::HsvSeg2Lo) begin
      seg = hsv2rgb_pkg::SEG_RG;
      pos = 32'(pix.hue);
    end else if (pix.hue < hsv2rgb_pkg::HsvSeg3Lo) begin
      seg = hsv2rgb_pkg::SEG_GB;
      pos = pix.hue - hsv2rgb_pkg::HsvSeg;
    end else begin
      seg = hsv2rgb_pkg::SEG_BR;
      pos = pix.hue - hsv2rgb_pkg::HsvSeg3Of;
    end
    rise = pos * hsv2rgb_pkg::HsvStep;
    fall = (hsv2rgb_pkg::HsvSeg - pos) * hsv2rgb_pkg::HsvStep;
    // Clamp the ramps to the ceiling
    if (rise > hsv2rgb_pkg::HsvClamp) rise = hsv2rgb_pkg::HsvClamp;
    if (fall > hsv2rgb_pkg::HsvClamp) fall = hsv2rgb_pkg::HsvClamp;
    case (seg)
      hsv2rgb_pkg::SEG_RG: begin
        ramp_r = fall;
        ramp_g = rise;
        ramp_b = 0;
      end
      hsv2rgb_pkg::SEG_GB: begin
        ramp_r = 0;
        ramp_g = fall;
        ramp_b = rise;
      end
      default: begin
        ramp_r = rise;
        ramp_g = 0;
        ramp_b = fall;
      end
    endcase
    rgb.red_out   = blend_channel(ramp_r, pix.saturation, pix.brightness);
    rgb.green_out = blend_channel(ramp_g, pix.saturation, pix.brightness);
    rgb.blue_out  = blend_channel(ramp_b, pix.saturation, pix.brightness);
    return rgb;
  endfunction

  // Report one field mismatch
  task automatic report_field(input string fname, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $realtime, fname, exp_v, act_v);
      err_cnt_o = err_cnt_o + 1;
    end
  endtask

  initial begin
    err_cnt_o  = 0;
    pend_cnt_o = 0;
  end

  // Score result beats, then queue the colour of each accepted pixel beat
  always @(posedge clk_i) begin
    hsv2rgb_pkg::rgb_pix_t exp_rgb;
    if (rst_ni) begin
      if (pix_out_mon.valid === 1'b1 && pix_out_mon.ready === 1'b1) begin
        if (rgb_exp_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d",
                   $realtime, pix_out_mon.data.red_out,
                   pix_out_mon.data.green_out, pix_out_mon.data.blue_out);
          err_cnt_o = err_cnt_o + 1;
        end else begin
          exp_rgb = rgb_exp_q.pop_front();
          report_field("red_out", exp_rgb.red_out, pix_out_mon.data.red_out);
          report_field("green_out", exp_rgb.green_out, pix_out_mon.data.green_out);
          report_field("blue_out", exp_rgb.blue_out, pix_out_mon.data.blue_out);
        end
      end
      if (pix_in_mon.valid === 1'b1 && pix_in_mon.ready === 1'b1)
        rgb_exp_q.push_back(hsv_to_rgb(pix_in_mon.data));
    end
    pend_cnt_o = rgb_exp_q.size();
  end

endmodule

FILE: dv/hsv_to_rgb_colour_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_colour_converter_tb
// Stimulus and verdict for the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
// Drives a directed set of pixels at the segment edges and the saturation
// and brightness extremes, pauses until the pipeline is empty, then sends
// random pixels in three phases of backpressure: a slow sender with a
// mostly stalled receiver, the reverse, and full rate on both sides. The
// checker beside the block scores every result beat.

module hsv_to_rgb_colour_converter_tb;

  localparam int PixPerPhase = 450;
  localparam int TailCycles  = 12;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   err_cnt;
  int   pend_cnt;

  hsv2rgb_in_if  pix_in_if ();
  hsv2rgb_out_if pix_out_if ();

  hsv_to_rgb_colour_converter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pix_in_if),
    .out_o  (pix_out_if)
  );

  hsv_to_rgb_colour_converter_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pix_in_mon  (pix_in_if),
    .pix_out_mon (pix_out_if),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_out_if.ready <= 1'b0;
    end else begin
      pix_out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Send one pixel beat after random idle cycles; start and end on a rising edge
  task automatic send_pix(input logic [7:0] hue, input logic [7:0] sat,
                          input logic [7:0] bri);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_if.valid           <= 1'b1;
    pix_in_if.data.hue        <= hue;
    pix_in_if.data.saturation <= sat;
    pix_in_if.data.brightness <= bri;
    do @(negedge clk); while (pix_in_if.ready !== 1'b1);
    @(posedge clk);
  endtask

  // Hold the sender until every queued colour has come out
  task automatic wait_drained();
    pix_in_if.valid <= 1'b0;
    do @(negedge clk); while (pend_cnt != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    rst_n = 1'b0;
    pix_in_if.valid <= 1'b0;
    pix_in_if.data  <= '0;
    src_idle_pct    <= 33;
    sink_idle_pct   <= 78;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Segment edges at full saturation and nominal brightness
    send_pix(8'd0, 8'd255, 8'd128);
    send_pix(8'd1, 8'd255, 8'd128);
    send_pix(8'd42, 8'd255, 8'd128);
    send_pix(8'd84, 8'd255, 8'd128);
    send_pix(8'd85, 8'd255, 8'd128);
    send_pix(8'd86, 8'd255, 8'd128);
    send_pix(8'd170, 8'd255, 8'd128);
    send_pix(8'd171, 8'd255, 8'd128);
    send_pix(8'd254, 8'd255, 8'd128);
    send_pix(8'd255, 8'd255, 8'd128);
    // Grey, black and toward-white extremes
    send_pix(8'd0, 8'd0, 8'd128);
    send_pix(8'd128, 8'd0, 8'd255);
    send_pix(8'd200, 8'd0, 8'd0);
    send_pix(8'd85, 8'd255, 8'd0);
    send_pix(8'd0, 8'd255, 8'd255);
    send_pix(8'd170, 8'd255, 8'd255);
    send_pix(8'd255, 8'd255, 8'd255);
    send_pix(8'd255, 8'd255, 8'd1);
    // Brightness either side of the blend switch
    send_pix(8'd60, 8'd200, 8'd127);
    send_pix(8'd60, 8'd200, 8'd129);
    send_pix(8'd120, 8'd1, 8'd129);
    send_pix(8'd210, 8'd128, 8'd127);
    send_pix(8'd0, 8'd0, 8'd0);
    send_pix(8'd255, 8'd0, 8'd255);
    wait_drained();

    // Random pixels under three backpressure phases
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  <= (phase == 0) ? 33 : (phase == 1) ? 78 : 0;
      sink_idle_pct <= (phase == 0) ? 78 : (phase == 1) ? 33 : 0;
      repeat (PixPerPhase) begin
        hue = 8'($urandom_range(255));
        sat = 8'($urandom_range(255));
        bri = 8'($urandom_range(255));
        // Bias part of the hues to segment edges
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(5))
            0: hue = 8'($urandom_range(1));
            1: hue = 8'(84 + $urandom_range(3));
            2: hue = 8'(169 + $urandom_range(3));
            3: hue = 8'(254 + $urandom_range(1));
            default: hue = 8'd85;
          endcase
        end
        // Bias part of saturation and brightness to their extremes, and part of brightness to the blend switch
        if ($urandom_range(4) == 0) sat = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        if ($urandom_range(4) == 0) bri = 8'(126 + $urandom_range(4));
        if ($urandom_range(9) == 0) bri = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        send_pix(hue, sat, bri);
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
